// ===== rtl/core/aes_pkg.sv =====
// AES encryption package: S-box table, GF(2^8) helpers and the round function.
// Used by aes_block_encrypt; no dependencies.
`default_nettype none

package aes_pkg;

    localparam int NUM_STAGES = 14;          // round stages after the initial key add
    localparam int SCHED_WORDS = 60;         // key schedule words for a 256-bit key
    localparam int SCHED_IDX_W = 6;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_MODE = 3'd4;

    localparam logic [7:0] GF_POLY = 8'h1b;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        gf_double = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        sub_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        d0 = gf_double(a0);
        d1 = gf_double(a1);
        d2 = gf_double(a2);
        d3 = gf_double(a3);
        mix_col = {d0 ^ d1 ^ a1 ^ a2 ^ a3,
                   a0 ^ d1 ^ d2 ^ a2 ^ a3,
                   a0 ^ a1 ^ d2 ^ d3 ^ a3,
                   d0 ^ a0 ^ a1 ^ a2 ^ d3};
    endfunction

    // One cipher round on a column-major state, byte 0 in bits 127:120.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [127:0] t;
        logic [127:0] m;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            m[127 - 32 * c -: 32] = last ? t[127 - 32 * c -: 32] : mix_col(t[127 - 32 * c -: 32]);
        end
        aes_round = m ^ rk;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aes_block_encrypt.sv =====
//  channel | signals                              | handshake
//  input   | plain_hi, plain_lo                   | in_valid / in_ready
//  output  | cipher_hi, cipher_lo                 | out_valid / out_ready
//  config  | cfg_index, cfg_wdata                 | cfg_we (no wait)
// One word per cycle unless the output stalls or the key schedule runs; the initial key add, then one round per stage.
// Short keys pass unchanged through the trailing stages after their final round.
// After reset and after every config write the key schedule runs one word per cycle,
// computing 44, 52 or 60 words for 128, 192 or 256-bit keys; in_ready stays low meanwhile.
// A stall at the output freezes the whole pipeline.
// Depends on aes_pkg.
`default_nettype none

module aes_block_encrypt
    import aes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] plain_hi,
    input  wire logic [63:0] plain_lo,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      cipher_hi,
    output logic [63:0]      cipher_lo
);

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg;
    logic [1:0]   mode_reg;
    logic         busy_reg;
    logic [SCHED_IDX_W-1:0] idx_reg, idx_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [7:0]   rc_reg, rc_next;
    logic [31:0]  win_reg [8];
    logic [31:0]  sched_reg [SCHED_WORDS];
    logic [31:0]  word_next;
    logic [2:0]   nk_last;
    logic [SCHED_IDX_W-1:0] idx_last;
    logic [3:0]   nr;
    logic [255:0] key_all;
    logic [31:0]  t;

    logic         adv;
    logic [127:0] st_reg [NUM_STAGES + 1];
    logic         v_reg [NUM_STAGES + 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            mode_reg <= MODE_128;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY0: key0_reg <= cfg_wdata;
                REG_KEY1: key1_reg <= cfg_wdata;
                REG_KEY2: key2_reg <= cfg_wdata;
                REG_KEY3: key3_reg <= cfg_wdata;
                REG_MODE: mode_reg <= cfg_wdata[1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_128:
            begin
                nk_last  = 3'd3;
                idx_last = SCHED_IDX_W'(43);
                nr       = 4'd10;
            end
            MODE_192:
            begin
                nk_last  = 3'd5;
                idx_last = SCHED_IDX_W'(51);
                nr       = 4'd12;
            end
            default:
            begin
                nk_last  = 3'd7;
                idx_last = SCHED_IDX_W'(59);
                nr       = 4'd14;
            end
        endcase
    end

    // Key schedule: one word per cycle, last eight words held in a window.
    assign key_all = {key0_reg, key1_reg, key2_reg, key3_reg};

    always_comb
    begin
        t       = win_reg[0];
        rc_next = rc_reg;
        if (idx_reg <= SCHED_IDX_W'(nk_last))
        begin
            word_next = key_all[255 - 32 * idx_reg[2:0] -: 32];
        end
        else
        begin
            if (cnt_reg == 3'd0)
            begin
                t       = sub_word({t[23:0], t[31:24]}) ^ {rc_reg, 24'h0};
                rc_next = gf_double(rc_reg);
            end
            else if (nk_last == 3'd7 && cnt_reg == 3'd4)
            begin
                t = sub_word(t);
            end
            word_next = win_reg[nk_last] ^ t;
        end
        cnt_next = (cnt_reg == nk_last) ? 3'd0 : cnt_reg + 3'd1;
        idx_next = idx_reg + SCHED_IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            cnt_reg  <= '0;
            rc_reg   <= 8'h01;
        end
        else if (cfg_we)
        begin
            // restart the schedule on any write
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            cnt_reg  <= '0;
            rc_reg   <= 8'h01;
        end
        else if (busy_reg)
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            rc_reg  <= rc_next;
            if (idx_reg == idx_last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_we)
        begin
            sched_reg[idx_reg] <= word_next;
            win_reg[0] <= word_next;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k - 1];
            end
        end
    end

    // Round pipeline: advance unless the output word is stalled.
    assign adv      = !v_reg[NUM_STAGES] || out_ready;
    assign in_ready = adv && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r <= NUM_STAGES; r++)
            begin
                v_reg[r] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid && !busy_reg;
            for (int r = 1; r <= NUM_STAGES; r++)
            begin
                v_reg[r] <= v_reg[r - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= {plain_hi, plain_lo} ^
                         {sched_reg[0], sched_reg[1], sched_reg[2], sched_reg[3]};
        end
    end

    for (genvar r = 1; r <= NUM_STAGES; r++)
    begin : g_round
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (4'(r) > nr)
                begin
                    st_reg[r] <= st_reg[r - 1];
                end
                else
                begin
                    st_reg[r] <= aes_round(st_reg[r - 1],
                                           {sched_reg[4 * r], sched_reg[4 * r + 1],
                                            sched_reg[4 * r + 2], sched_reg[4 * r + 3]},
                                           4'(r) == nr);
                end
            end
        end
    end

    assign out_valid = v_reg[NUM_STAGES];
    assign cipher_hi = st_reg[NUM_STAGES][127:64];
    assign cipher_lo = st_reg[NUM_STAGES][63:0];

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ready)
        else $error("input taken during key expansion");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy_reg && idx_reg == '0)
        else $error("config write did not restart key expansion");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= idx_last)
        else $error("key schedule index overrun");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(st_reg[NUM_STAGES]))
        else $error("stalled output word changed");
`endif

endmodule

`default_nettype wire
